// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file scma_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every rising clock edge, during reset too.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/scma_pkg.sv =====
`timescale 1ns / 1ps
package scma_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_START = 2'd0,
    OP_LOAD_ENTRY = 2'd1,
    OP_B_ENTRY    = 2'd2,
    OP_CLOSE      = 2'd3
  } opcode_e;

  localparam logic [0:0] CFG_ROWS_IN_USE    = 1'b0;
  localparam logic [0:0] CFG_DROP_THRESHOLD = 1'b1;

  localparam int unsigned ValueW = 32;
  localparam int unsigned SumW   = 64;
  localparam int unsigned RowW   = 6;
  localparam int unsigned PtrW   = 11;
  localparam int unsigned CfgW   = 32;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  function automatic logic signed [SumW-1:0] sat_add(
    input logic signed [SumW-1:0] a,
    input logic signed [SumW-1:0] b
  );
    logic signed [SumW:0] s;
    s = {a[SumW-1], a} + {b[SumW-1], b};
    if (s[SumW] != s[SumW-1]) begin
      return s[SumW] ? SumMin : SumMax;
    end
    return s[SumW-1:0];
  endfunction

endpackage

// ===== hw/rtl/scma_ram.sv =====
`timescale 1ns / 1ps
module scma_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/scma_mac.sv =====
`timescale 1ns / 1ps
module scma_mac import scma_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [ValueW-1:0] a_i,
  input  logic signed [ValueW-1:0] b_i,
  output logic signed [SumW-1:0]   prod_o
);

  logic signed [SumW-1:0] prod_d;

  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    prod_o <= prod_d;
  end

endmodule

// ===== hw/rtl/sparse_column_multiply_accumulate_unit.sv =====
`timescale 1ns / 1ps
// Sparse column multiply accumulate unit: C = A * B, columns compressed.
// Input channel (in_valid_i / in_ready_o) takes one beat per item: loads of
// A column starts (opcode 0), loads of A entries (opcode 1), B entries
// (opcode 2) and column closes (opcode 3). Output channel (out_valid_o /
// out_ready_i) gives one beat per kept result of a closed column, or one
// empty-marked beat when nothing was kept.
// A load is written as it is taken. A B entry reads the A column's start
// and end pointers, then walks the column one A entry at a time through
// one shared multiplier and one saturating adder over the accumulator memory.
// A column end scans rows 0..min(rows_in_use, MAX_ROWS)-1, each row through
// S_SCAN_RD and S_SCAN_CHK, holding each kept sum back by one kept row so
// that the final beat can be marked last. S_OUT sends the final beat, and
// then all MAX_ROWS sums are cleared, one per cycle.
// The block takes no new beat while an item is at work. When the receiver
// stalls, the scan waits on the held result beat.
// Reset clears the accumulator by one pass over all MAX_ROWS rows, during which
// no beat is taken; configuration writes are taken at any time and return
// rows_in_use to 64 and drop_threshold to 0 at reset.
module sparse_column_multiply_accumulate_unit import scma_pkg::*; #(
  parameter int unsigned MAX_ROWS   = 64,
  parameter int unsigned MAX_A_COLS = 64,
  parameter int unsigned MAX_NNZ    = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [0:0]               cfg_index_i,
  input  logic [CfgW-1:0]          cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               opcode_i,
  input  logic [9:0]               slot_i,
  input  logic [PtrW-1:0]          start_pointer_i,
  input  logic [RowW-1:0]          row_i,
  input  logic signed [ValueW-1:0] entry_value_i,
  input  logic                     end_of_column_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [RowW-1:0]          out_row_o,
  output logic signed [SumW-1:0]   out_sum_o,
  output logic                     last_o,
  output logic                     column_empty_o
);

  localparam int unsigned ColD  = MAX_A_COLS + 1;
  localparam int unsigned ColAW = $clog2(ColD);
  localparam int unsigned NzAW  = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;
  localparam int unsigned RAW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned NzCW  = $clog2(MAX_NNZ + 1) > PtrW ? $clog2(MAX_NNZ + 1) : PtrW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_S, S_RD_E, S_WALK_RD, S_WALK_MUL, S_WALK_ADD,
    S_SCAN_RD, S_SCAN_CHK, S_OUT, S_ZERO
  } state_e;

  state_e state_q;
  logic [6:0]       rows_in_use_q;
  logic [CfgW-1:0]  drop_threshold_q;
  logic signed [ValueW-1:0] bval_q;
  logic             eoc_q;
  logic [NzCW-1:0]  k_q, e_q;
  logic [CntW-1:0]  r_q;
  logic             kept_q;
  logic [RowW-1:0]  pend_row_q;
  logic signed [SumW-1:0] pend_sum_q;
  logic [RowW-1:0]  out_row_q;
  logic signed [SumW-1:0] out_sum_q;
  logic             out_valid_q, last_q, empty_q;

  logic             col_we, nz_we, acc_we;
  logic [ColAW-1:0] col_waddr, col_raddr;
  logic [PtrW-1:0]  col_rdata;
  logic [NzAW-1:0]  nz_raddr;
  logic [RowW-1:0]  arow_rdata;
  logic signed [ValueW-1:0] aval_rdata;
  logic [RAW-1:0]   acc_waddr, acc_raddr;
  logic signed [SumW-1:0] acc_wdata, acc_rdata, prod;
  logic [RowW-1:0]  arow_q;

  logic [CntW-1:0] n_rows;
  assign n_rows = (rows_in_use_q > 7'(MAX_ROWS)) ? CntW'(MAX_ROWS) : CntW'(rows_in_use_q);

  logic accept;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept = in_valid_i && in_ready_o;

  assign col_we    = accept && opcode_i == OP_LOAD_START && 32'(slot_i) <= MAX_A_COLS;
  assign col_waddr = ColAW'(slot_i);
  assign nz_we     = accept && opcode_i == OP_LOAD_ENTRY && 32'(slot_i) < MAX_NNZ;

  scma_ram #(.Width(PtrW), .Depth(ColD)) u_col (
    .clk_i, .we_i(col_we), .waddr_i(col_waddr), .wdata_i(start_pointer_i),
    .raddr_i(col_raddr), .rdata_o(col_rdata));
  scma_ram #(.Width(RowW), .Depth(MAX_NNZ)) u_arow (
    .clk_i, .we_i(nz_we), .waddr_i(NzAW'(slot_i)), .wdata_i(row_i),
    .raddr_i(nz_raddr), .rdata_o(arow_rdata));
  scma_ram #(.Width(ValueW), .Depth(MAX_NNZ)) u_aval (
    .clk_i, .we_i(nz_we), .waddr_i(NzAW'(slot_i)), .wdata_i(entry_value_i),
    .raddr_i(nz_raddr), .rdata_o(aval_rdata));
  scma_ram #(.Width(SumW), .Depth(MAX_ROWS)) u_acc (
    .clk_i, .we_i(acc_we), .waddr_i(acc_waddr), .wdata_i(acc_wdata),
    .raddr_i(acc_raddr), .rdata_o(acc_rdata));
  scma_mac u_mac (.clk_i, .a_i(aval_rdata), .b_i(bval_q), .prod_o(prod));

  assign nz_raddr = NzAW'(k_q);

  always_comb begin
    col_raddr = ColAW'(row_i);
    if (state_q == S_RD_S) col_raddr = ColAW'(k_q[ColAW-1:0] + 1'b1);
  end

  always_comb begin
    acc_raddr = RAW'(r_q);
    if (state_q == S_WALK_MUL) acc_raddr = RAW'(arow_rdata);
    acc_we    = 1'b0;
    acc_waddr = RAW'(r_q);
    acc_wdata = '0;
    if (state_q == S_CLEAR || state_q == S_ZERO) acc_we = 1'b1;
    if (state_q == S_WALK_ADD && 32'(arow_q) < MAX_ROWS) begin
      acc_we    = 1'b1;
      acc_waddr = RAW'(arow_q);
      acc_wdata = sat_add(acc_rdata, prod);
    end
  end

  logic [SumW-1:0] mag;
  assign mag = acc_rdata[SumW-1] ? SumW'(-acc_rdata) : acc_rdata;

  logic keep_row, out_free, out_load;
  assign keep_row = mag > SumW'(drop_threshold_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = out_free &&
                    ((state_q == S_SCAN_CHK && keep_row && kept_q) || state_q == S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_CLEAR;
      rows_in_use_q    <= 7'd64;
      drop_threshold_q <= '0;
      bval_q           <= '0;
      arow_q           <= '0;
      r_q              <= '0;
      k_q              <= '0;
      e_q              <= '0;
      eoc_q            <= 1'b0;
      kept_q           <= 1'b0;
      pend_row_q       <= '0;
      pend_sum_q       <= '0;
      out_row_q        <= '0;
      out_sum_q        <= '0;
      out_valid_q      <= 1'b0;
      last_q           <= 1'b0;
      empty_q          <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ROWS_IN_USE:    rows_in_use_q <= cfg_wdata_i[6:0];
          CFG_DROP_THRESHOLD: drop_threshold_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR, S_ZERO: begin
          if (r_q == CntW'(MAX_ROWS - 1)) begin
            r_q     <= '0;
            state_q <= S_IDLE;
          end else begin
            r_q <= r_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            bval_q <= entry_value_i;
            eoc_q  <= end_of_column_i;
            r_q    <= '0;
            kept_q <= 1'b0;
            k_q    <= NzCW'(row_i);
            case (opcode_i)
              OP_B_ENTRY: begin
                if (32'(row_i) < MAX_A_COLS) state_q <= S_RD_S;
                else if (end_of_column_i) state_q <= S_SCAN_RD;
              end
              OP_CLOSE: state_q <= S_SCAN_RD;
              default: ;
            endcase
          end
        end
        S_RD_S: begin
          k_q     <= NzCW'(col_rdata);
          state_q <= S_RD_E;
        end
        S_RD_E: begin
          e_q     <= (32'(col_rdata) > MAX_NNZ) ? NzCW'(MAX_NNZ) : NzCW'(col_rdata);
          state_q <= S_WALK_RD;
        end
        S_WALK_RD: begin
          if (k_q < e_q) state_q <= S_WALK_MUL;
          else if (eoc_q) state_q <= S_SCAN_RD;
          else state_q <= S_IDLE;
        end
        S_WALK_MUL: begin
          arow_q  <= arow_rdata;
          state_q <= S_WALK_ADD;
        end
        S_WALK_ADD: begin
          k_q     <= k_q + 1'b1;
          state_q <= S_WALK_RD;
        end
        S_SCAN_RD: begin
          if (r_q >= n_rows) state_q <= S_OUT;
          else state_q <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (keep_row) begin
            if (!kept_q || out_free) begin
              if (kept_q) begin
                out_row_q <= pend_row_q;
                out_sum_q <= pend_sum_q;
                empty_q   <= 1'b0;
                last_q    <= 1'b0;
              end
              pend_row_q <= RowW'(r_q);
              pend_sum_q <= acc_rdata;
              kept_q     <= 1'b1;
              r_q        <= r_q + 1'b1;
              state_q    <= S_SCAN_RD;
            end
          end else begin
            r_q     <= r_q + 1'b1;
            state_q <= S_SCAN_RD;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_row_q <= kept_q ? pend_row_q : '0;
            out_sum_q <= kept_q ? pend_sum_q : '0;
            empty_q   <= !kept_q;
            last_q    <= 1'b1;
            kept_q    <= 1'b0;
            r_q       <= '0;
            state_q   <= S_ZERO;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_row_o      = out_row_q;
  assign out_sum_o      = out_sum_q;
  assign last_o         = last_q;
  assign column_empty_o = empty_q;

endmodule

// ===== hw/rtl/scma_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scma_checker import scma_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [RowW-1:0]        out_row_o,
  input logic signed [SumW-1:0] out_sum_o,
  input logic                   last_o,
  input logic                   column_empty_o
);

  logic empty_beat;
  logic out_stall;
  logic [RowW+SumW+1:0] out_payload;

  assign empty_beat  = out_valid_o && column_empty_o;
  assign out_stall   = out_valid_o && !out_ready_i;
  assign out_payload = {out_row_o, out_sum_o, last_o, column_empty_o};

  `ASSERT_IMPL(empty_is_last, clk_i, rst_ni, empty_beat |-> last_o, "empty beat not last")
  `ASSERT_IMPL(out_holds, clk_i, rst_ni, out_stall |=> out_valid_o, "result beat dropped")
  `ASSERT_IMPL(out_stable, clk_i, rst_ni, out_stall |=> $stable(out_payload), "beat changed")
  `ASSERT_ALWAYS(no_out_in_reset, clk_i, !rst_ni |-> !out_valid_o, "result beat in reset")

endmodule

bind sparse_column_multiply_accumulate_unit scma_checker u_scma_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .out_row_o, .out_sum_o,
  .last_o, .column_empty_o);
